// ===== design/slea_pkg.sv =====
// ----------------------------------------------------------------------------
// slea_pkg
// Shared types, constants and helpers for the serial latch expander access
// block: beat payloads, configuration set, sequencer phases.
// ----------------------------------------------------------------------------
`default_nettype none

package slea_pkg;

	// shadow word geometry
	localparam int SHADOW_BITS = 64;
	localparam int WORD_BITS   = 64;
	localparam int COUNT_BITS  = 7;
	localparam int CFG_IDX_BITS = 3;

	// shadow reset value of latch zero (board build constant)
	localparam logic [WORD_BITS-1:0] FIRST_SHADOW_RESET = '0;

	// bits of the shadow that exist
	localparam logic [WORD_BITS-1:0] SHADOW_MASK =
		{WORD_BITS{1'b1}} >> (WORD_BITS - SHADOW_BITS);

	localparam logic [COUNT_BITS-1:0] SHADOW_LIMIT = COUNT_BITS'(SHADOW_BITS);
	localparam logic [COUNT_BITS-1:0] WORD_LIMIT   = COUNT_BITS'(WORD_BITS);

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_OUT  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_IN   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SECOND_OUT = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SECOND_IN  = 3'd3;

	// configuration reset values
	localparam logic [COUNT_BITS-1:0] FIRST_OUT_RESET  = 7'd16;
	localparam logic [COUNT_BITS-1:0] FIRST_IN_RESET   = 7'd0;
	localparam logic [COUNT_BITS-1:0] SECOND_OUT_RESET = 7'd40;
	localparam logic [COUNT_BITS-1:0] SECOND_IN_RESET  = 7'd32;

	// input beat commands
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_START = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_OUT_LOW  = 3'd1,
		PH_OUT_HIGH = 3'd2,
		PH_STROBE   = 3'd3,
		PH_IN_LOW   = 3'd4,
		PH_IN_HIGH  = 3'd5
	} phase_t;

	typedef struct packed {
		logic                 command;
		logic                 latch_select;
		logic [WORD_BITS-1:0] write_value;
		logic [WORD_BITS-1:0] write_mask;
		logic                 serial_in;
	} in_item_t;

	typedef struct packed {
		logic                 serial_clock;
		logic                 serial_data_out;
		logic                 strobe_first;
		logic                 strobe_second;
		logic                 busy_res;
		logic                 done_res;
		logic [WORD_BITS-1:0] read_data;
	} out_item_t;

	typedef struct packed {
		logic [COUNT_BITS-1:0] first_out_bits;
		logic [COUNT_BITS-1:0] first_in_bits;
		logic [COUNT_BITS-1:0] second_out_bits;
		logic [COUNT_BITS-1:0] second_in_bits;
	} cfg_t;

	// clamp a bit count to a limit
	function automatic logic [COUNT_BITS-1:0] sat_count(
		input logic [COUNT_BITS-1:0] n,
		input logic [COUNT_BITS-1:0] lim
	);
		return (n > lim) ? lim : n;
	endfunction

endpackage

`default_nettype wire

// ===== design/slea_cfg.sv =====
// ----------------------------------------------------------------------------
// slea_cfg
// Configuration register file: four bit-count registers behind a plain
// write port, unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module slea_cfg
	import slea_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [COUNT_BITS-1:0]   cfg_data,
	output cfg_t                         cfg
);

	cfg_t cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_out_bits  <= FIRST_OUT_RESET;
			cfg_q.first_in_bits   <= FIRST_IN_RESET;
			cfg_q.second_out_bits <= SECOND_OUT_RESET;
			cfg_q.second_in_bits  <= SECOND_IN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FIRST_OUT:  cfg_q.first_out_bits  <= cfg_data;
				CFG_FIRST_IN:   cfg_q.first_in_bits   <= cfg_data;
				CFG_SECOND_OUT: cfg_q.second_out_bits <= cfg_data;
				CFG_SECOND_IN:  cfg_q.second_in_bits  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== design/slea_engine.sv =====
// ----------------------------------------------------------------------------
// slea_engine
// Access sequencer: shadow words, phase, bit counter, gathered word and pin
// levels. One beat is processed per fire; the result shows the pins after it.
// ----------------------------------------------------------------------------
`default_nettype none

module slea_engine
	import slea_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      fire,
	input  wire in_item_t  item,
	input  wire cfg_t      cfg,
	output out_item_t      res
);

	phase_t                phase_q, phase_n;
	logic [WORD_BITS-1:0]  shadow0_q, shadow1_q, shadow0_n, shadow1_n;
	logic [COUNT_BITS-1:0] count_q, count_n;
	logic                  active_q, active_n;
	logic [WORD_BITS-1:0]  gather_q, gather_n;
	logic                  clock_q, clock_n;
	logic                  data_q, data_n;
	logic                  strobe0_q, strobe0_n;
	logic                  strobe1_q, strobe1_n;
	logic                  done;
	logic [WORD_BITS-1:0]  rdata;

	logic [WORD_BITS-1:0]  sel_shadow, merged, act_shadow;
	logic [COUNT_BITS-1:0] out_cnt_sel, out_cnt_act, in_cnt_act, count_inc;
	logic                  is_start, is_tick;

	// counts and shadow selection
	always_comb begin
		sel_shadow  = item.latch_select ? shadow1_q : shadow0_q;
		act_shadow  = active_q ? shadow1_q : shadow0_q;
		merged      = ((sel_shadow & ~item.write_mask) |
			(item.write_value & item.write_mask)) & SHADOW_MASK;
		out_cnt_sel = sat_count(item.latch_select ? cfg.second_out_bits
			: cfg.first_out_bits, SHADOW_LIMIT);
		out_cnt_act = sat_count(active_q ? cfg.second_out_bits
			: cfg.first_out_bits, SHADOW_LIMIT);
		in_cnt_act  = sat_count(active_q ? cfg.second_in_bits
			: cfg.first_in_bits, WORD_LIMIT);
		count_inc   = count_q + COUNT_BITS'(1);
		is_start    = fire && (item.command == CMD_START);
		is_tick     = fire && (item.command == CMD_TICK);
	end

	// next phase
	always_comb begin
		phase_n = phase_q;
		if (is_start) begin
			if (phase_q == PH_IDLE) begin
				phase_n = (out_cnt_sel != '0) ? PH_OUT_LOW : PH_STROBE;
			end
		end else if (is_tick) begin
			case (phase_q)
				PH_IDLE:     phase_n = PH_IDLE;
				PH_OUT_LOW:  phase_n = PH_OUT_HIGH;
				PH_OUT_HIGH: phase_n = (count_inc >= out_cnt_act) ? PH_STROBE : PH_OUT_LOW;
				PH_STROBE:   phase_n = (in_cnt_act == '0) ? PH_IDLE : PH_IN_LOW;
				PH_IN_LOW:   phase_n = PH_IN_HIGH;
				PH_IN_HIGH:  phase_n = (count_inc >= in_cnt_act) ? PH_IDLE : PH_IN_LOW;
				default:     phase_n = PH_IDLE;
			endcase
		end
	end

	// datapath and pin updates
	always_comb begin
		shadow0_n = shadow0_q;
		shadow1_n = shadow1_q;
		count_n   = count_q;
		active_n  = active_q;
		gather_n  = gather_q;
		clock_n   = clock_q;
		data_n    = data_q;
		strobe0_n = strobe0_q;
		strobe1_n = strobe1_q;
		done      = 1'b0;
		rdata     = '0;
		if (is_start) begin
			if (phase_q == PH_IDLE) begin
				active_n = item.latch_select;
				count_n  = '0;
				if (item.latch_select) begin
					shadow1_n = merged;
					strobe1_n = 1'b0;
				end else begin
					shadow0_n = merged;
					strobe0_n = 1'b0;
				end
			end
		end else if (is_tick) begin
			case (phase_q)
				PH_OUT_LOW: begin
					clock_n = 1'b0;
					data_n  = (count_q < WORD_LIMIT) ? act_shadow[count_q[5:0]] : 1'b0;
				end
				PH_OUT_HIGH: begin
					clock_n = 1'b1;
					count_n = count_inc;
				end
				PH_STROBE: begin
					if (active_q) strobe1_n = 1'b1;
					else strobe0_n = 1'b1;
					count_n  = '0;
					gather_n = '0;
					done     = (in_cnt_act == '0);
				end
				PH_IN_LOW: begin
					clock_n = 1'b0;
				end
				PH_IN_HIGH: begin
					gather_n = {gather_q[WORD_BITS-2:0], item.serial_in};
					clock_n  = 1'b1;
					count_n  = count_inc;
					if (count_inc >= in_cnt_act) begin
						done  = 1'b1;
						rdata = gather_n;
					end
				end
				default: ;
			endcase
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			shadow0_q <= FIRST_SHADOW_RESET & SHADOW_MASK;
			shadow1_q <= '0;
			count_q   <= '0;
			active_q  <= 1'b0;
			gather_q  <= '0;
			clock_q   <= 1'b1;
			data_q    <= 1'b0;
			strobe0_q <= 1'b1;
			strobe1_q <= 1'b1;
		end else if (fire) begin
			phase_q   <= phase_n;
			shadow0_q <= shadow0_n;
			shadow1_q <= shadow1_n;
			count_q   <= count_n;
			active_q  <= active_n;
			gather_q  <= gather_n;
			clock_q   <= clock_n;
			data_q    <= data_n;
			strobe0_q <= strobe0_n;
			strobe1_q <= strobe1_n;
		end
	end

	// result beat, pins after this item
	always_comb begin
		res.serial_clock    = clock_n;
		res.serial_data_out = data_n;
		res.strobe_first    = strobe0_n;
		res.strobe_second   = strobe1_n;
		res.busy_res        = (phase_n != PH_IDLE);
		res.done_res        = done;
		res.read_data       = rdata;
	end

endmodule

`default_nettype wire

// ===== design/serial_latch_expander_access.sv =====
// ----------------------------------------------------------------------------
// serial_latch_expander_access
// Controller for two chained shift-register latches: merges writes into a
// shadow, shifts it out under strobe and reads bits back, one pin phase per
// tick beat.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+--------------------------------
//  in       | in        | in_valid/stall   | in_item (command, select, data)
//  out      | out       | out_valid/stall  | out_item (pins, busy, done, data)
//  cfg      | in        | cfg_we           | cfg_index, cfg_data
//
// Every input beat yields one result beat, through an input register and then
// the sequencer step into the result register. A beat can enter every cycle
// while in_stall is low.
// Reset is asynchronous and needs no clearing pass.
// A stalled result holds the pipeline; the input register still fills only
// while it is empty, and in_stall is raised once it holds a beat.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_latch_expander_access
	import slea_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire in_item_t                in_item,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output out_item_t                    out_item,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [COUNT_BITS-1:0]   cfg_data
);

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res;
	out_item_t res_s2;
	logic      valid_s2;
	logic      advance;
	logic      fire;

	slea_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// pipeline moves when the result register is free or being taken
	assign advance  = !valid_s2 || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1 <= in_item;
		end
	end

	slea_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = res_s2;

endmodule

`default_nettype wire

// ===== verif/serial_latch_expander_access_test.sv =====
// ----------------------------------------------------------------------------
// serial_latch_expander_access_test
// Self-checking bench for the serial latch expander access block. Beats are
// pushed through the valid/stall input channel while a local model of the
// sequencer predicts the pin levels, busy, done and read word of each result
// beat; a monitor compares every accepted result with the oldest prediction.
// Directed checks cover idle ticks, zero counts and starts while busy; random
// accesses follow under several count settings, saturating ones included.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module serial_latch_expander_access_test;
	import slea_pkg::*;

	localparam int RANDOM_BEATS = 1400;
	localparam int PHASE_BEATS  = 200;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int PRINT_LIMIT  = 40;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	in_item_t                in_item = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	out_item_t               out_item;
	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [COUNT_BITS-1:0]   cfg_data = '0;

	// predicted sequencer state and count settings
	logic [WORD_BITS-1:0]  exp_shadow [2];
	phase_t                exp_phase;
	int                    exp_bit_count;
	logic                  exp_latch;
	logic [WORD_BITS-1:0]  exp_gather;
	logic                  exp_clock;
	logic                  exp_data;
	logic                  exp_strobe [2];
	logic [COUNT_BITS-1:0] exp_out_bits [2];
	logic [COUNT_BITS-1:0] exp_in_bits [2];

	out_item_t expected_pins [$];
	int        mismatches = 0;
	int        results_seen = 0;
	int        access_beats = 0;
	int        cycles = 0;
	bit        steady = 1'b0;

	serial_latch_expander_access uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("serial_latch_expander_access verification failed");
			$finish;
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(99) < 8);
	end

	task automatic report_mismatch(input string what, input logic [WORD_BITS-1:0] got,
		input logic [WORD_BITS-1:0] want);
		if (mismatches < PRINT_LIMIT)
			$display("mismatch on result %0d, %s: got %h, expected %h",
				results_seen, what, got, want);
		mismatches++;
	endtask

	// effective shift lengths for the active latch
	function automatic int shift_out_len();
		int n;
		n = int'(exp_out_bits[exp_latch]);
		return (n > SHADOW_BITS) ? SHADOW_BITS : n;
	endfunction

	function automatic int shift_in_len();
		int n;
		n = int'(exp_in_bits[exp_latch]);
		return (n > WORD_BITS) ? WORD_BITS : n;
	endfunction

	// one sequencer step; returns the result beat it causes
	function automatic out_item_t expander_step(input in_item_t beat);
		out_item_t res;
		res = '0;
		if (beat.command == CMD_START) begin
			// a start while busy is dropped without touching anything
			if (exp_phase == PH_IDLE) begin
				exp_latch = beat.latch_select;
				exp_shadow[exp_latch] = ((exp_shadow[exp_latch] & ~beat.write_mask) |
					(beat.write_value & beat.write_mask)) & SHADOW_MASK;
				exp_strobe[exp_latch] = 1'b0;
				exp_bit_count = 0;
				exp_phase = (shift_out_len() > 0) ? PH_OUT_LOW : PH_STROBE;
			end
		end else begin
			case (exp_phase)
				PH_IDLE: ;
				PH_OUT_LOW: begin
					exp_clock = 1'b0;
					exp_data = exp_shadow[exp_latch][exp_bit_count];
					exp_phase = PH_OUT_HIGH;
				end
				PH_OUT_HIGH: begin
					exp_clock = 1'b1;
					exp_bit_count++;
					exp_phase = (exp_bit_count >= shift_out_len()) ? PH_STROBE : PH_OUT_LOW;
				end
				PH_STROBE: begin
					exp_strobe[exp_latch] = 1'b1;
					exp_bit_count = 0;
					exp_gather = '0;
					if (shift_in_len() == 0) begin
						res.done_res = 1'b1;
						exp_phase = PH_IDLE;
					end else begin
						exp_phase = PH_IN_LOW;
					end
				end
				PH_IN_LOW: begin
					exp_clock = 1'b0;
					exp_phase = PH_IN_HIGH;
				end
				PH_IN_HIGH: begin
					exp_gather = {exp_gather[WORD_BITS-2:0], beat.serial_in};
					exp_clock = 1'b1;
					exp_bit_count++;
					if (exp_bit_count >= shift_in_len()) begin
						res.done_res = 1'b1;
						res.read_data = exp_gather;
						exp_phase = PH_IDLE;
					end else begin
						exp_phase = PH_IN_LOW;
					end
				end
				default: exp_phase = PH_IDLE;
			endcase
		end
		res.serial_clock = exp_clock;
		res.serial_data_out = exp_data;
		res.strobe_first = exp_strobe[0];
		res.strobe_second = exp_strobe[1];
		res.busy_res = (exp_phase != PH_IDLE);
		return res;
	endfunction

	// result monitor
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_pins.size() == 0) begin
				report_mismatch("result with nothing expected", out_item.read_data, '0);
			end else begin
				want = expected_pins.pop_front();
				if (out_item.serial_clock !== want.serial_clock)
					report_mismatch("serial_clock", out_item.serial_clock, want.serial_clock);
				if (out_item.serial_data_out !== want.serial_data_out)
					report_mismatch("serial_data_out", out_item.serial_data_out,
						want.serial_data_out);
				if (out_item.strobe_first !== want.strobe_first)
					report_mismatch("strobe_first", out_item.strobe_first, want.strobe_first);
				if (out_item.strobe_second !== want.strobe_second)
					report_mismatch("strobe_second", out_item.strobe_second, want.strobe_second);
				if (out_item.busy_res !== want.busy_res)
					report_mismatch("busy_res", out_item.busy_res, want.busy_res);
				if (out_item.done_res !== want.done_res)
					report_mismatch("done_res", out_item.done_res, want.done_res);
				if (out_item.read_data !== want.read_data)
					report_mismatch("read_data", out_item.read_data, want.read_data);
			end
			results_seen++;
		end
	end

	// push one beat, with random gaps in front of it
	task automatic send_beat(input in_item_t beat);
		while (!steady && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= beat;
		do @(posedge clk); while (in_stall);
		expected_pins.push_back(expander_step(beat));
	endtask

	// stop sending until every predicted beat has come back
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_pins.size() != 0);
	endtask

	task automatic drain_results();
		hold_until_drained();
		repeat (6) @(posedge clk);
	endtask

	// write all four counts plus one out-of-range index with random data
	task automatic program_counts(input logic [COUNT_BITS-1:0] first_out,
		input logic [COUNT_BITS-1:0] first_in, input logic [COUNT_BITS-1:0] second_out,
		input logic [COUNT_BITS-1:0] second_in);
		logic [CFG_IDX_BITS-1:0] regs [5];
		logic [COUNT_BITS-1:0]   counts [4];
		logic [WORD_BITS-1:0]    word;
		drain_results();
		regs[0] = CFG_FIRST_OUT;
		regs[1] = CFG_FIRST_IN;
		regs[2] = CFG_SECOND_OUT;
		regs[3] = CFG_SECOND_IN;
		regs[4] = CFG_SECOND_IN + CFG_IDX_BITS'($urandom_range(1, 4));
		counts[0] = first_out;
		counts[1] = first_in;
		counts[2] = second_out;
		counts[3] = second_in;
		for (int i = 0; i < 5; i++) begin
			word = {$urandom, $urandom};
			if (i < 4)
				word[COUNT_BITS-1:0] = counts[i];
			cfg_we <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= word[COUNT_BITS-1:0];
			@(posedge clk);
			case (regs[i])
				CFG_FIRST_OUT:  exp_out_bits[0] = word[COUNT_BITS-1:0];
				CFG_FIRST_IN:   exp_in_bits[0] = word[COUNT_BITS-1:0];
				CFG_SECOND_OUT: exp_out_bits[1] = word[COUNT_BITS-1:0];
				CFG_SECOND_IN:  exp_in_bits[1] = word[COUNT_BITS-1:0];
				default: ;
			endcase
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [WORD_BITS-1:0] pick_word();
		logic [WORD_BITS-1:0] w;
		case ($urandom_range(9))
			0: w = '0;
			1: w = '1;
			default: w = {$urandom, $urandom};
		endcase
		return w;
	endfunction

	function automatic in_item_t random_tick();
		in_item_t beat;
		beat.command = CMD_TICK;
		beat.latch_select = 1'($urandom_range(1));
		beat.write_value = pick_word();
		beat.write_mask = pick_word();
		beat.serial_in = 1'($urandom_range(1));
		return beat;
	endfunction

	function automatic logic [COUNT_BITS-1:0] pick_count();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return COUNT_BITS'($urandom_range(0, 6));
		if (r < 85)
			return COUNT_BITS'($urandom_range(7, 24));
		return COUNT_BITS'($urandom_range(60, 127));
	endfunction

	// one full access with random content, optionally with stray starts
	task automatic run_access(input bit noisy);
		in_item_t beat;
		beat = random_tick();
		beat.command = CMD_START;
		send_beat(beat);
		access_beats++;
		while (exp_phase != PH_IDLE) begin
			beat = random_tick();
			if (noisy && $urandom_range(99) < 4)
				beat.command = CMD_START;
			else
				access_beats++;
			send_beat(beat);
		end
	endtask

	// ticks with no access running, extreme data on them
	task automatic test_idle_ticks();
		in_item_t beat;
		beat.command = CMD_TICK;
		beat.latch_select = 1'b1;
		beat.write_value = '1;
		beat.write_mask = '1;
		beat.serial_in = 1'b1;
		send_beat(beat);
		beat = '0;
		send_beat(beat);
		send_beat(random_tick());
	endtask

	// empty shift-in and shift-out, start while busy
	task automatic test_zero_counts();
		in_item_t beat;
		program_counts('0, '0, COUNT_BITS'(1), '0);
		beat = '0;
		beat.command = CMD_START;
		beat.write_value = '1;
		beat.write_mask = '1;
		send_beat(beat);
		send_beat(random_tick());
		// latch one untouched by the mask, so its reset shadow goes out
		beat = '0;
		beat.command = CMD_START;
		beat.latch_select = 1'b1;
		send_beat(beat);
		beat.latch_select = 1'b0;
		beat.write_mask = '1;
		send_beat(beat);
		repeat (3) send_beat(random_tick());
	endtask

	// a short read-back with a stray start and a full drain mid-access
	task automatic test_short_access();
		in_item_t beat;
		int n;
		program_counts(COUNT_BITS'(2), COUNT_BITS'(3), COUNT_BITS'(1), COUNT_BITS'(1));
		beat = random_tick();
		beat.command = CMD_START;
		beat.latch_select = 1'b0;
		beat.write_value = '1;
		beat.write_mask = 64'h5555_5555_5555_5556;
		send_beat(beat);
		n = 0;
		while (exp_phase != PH_IDLE) begin
			beat = random_tick();
			if (n == 2)
				beat.command = CMD_START;
			if (n == 4)
				hold_until_drained();
			send_beat(beat);
			n++;
		end
	endtask

	// random accesses over several count settings
	task automatic test_random_accesses();
		int phase_no;
		int phase_start;
		phase_no = 0;
		while (access_beats < RANDOM_BEATS) begin
			case (phase_no)
				0: program_counts(FIRST_OUT_RESET, FIRST_IN_RESET, SECOND_OUT_RESET,
					SECOND_IN_RESET);
				1: program_counts('1, '1, '1, '1);
				2: program_counts(COUNT_BITS'(64), COUNT_BITS'(65), COUNT_BITS'(63),
					COUNT_BITS'(64));
				default: program_counts(pick_count(), pick_count(), pick_count(), pick_count());
			endcase
			steady = (phase_no == 3);
			phase_start = access_beats;
			while (access_beats - phase_start < PHASE_BEATS) begin
				if ($urandom_range(9) == 0)
					repeat ($urandom_range(1, 3)) send_beat(random_tick());
				if ($urandom_range(49) == 0)
					hold_until_drained();
				run_access(1'b1);
			end
			phase_no++;
		end
		steady = 1'b0;
	endtask

	initial begin
		exp_shadow[0] = FIRST_SHADOW_RESET & SHADOW_MASK;
		exp_shadow[1] = '0;
		exp_phase = PH_IDLE;
		exp_bit_count = 0;
		exp_latch = 1'b0;
		exp_gather = '0;
		exp_clock = 1'b1;
		exp_data = 1'b0;
		exp_strobe[0] = 1'b1;
		exp_strobe[1] = 1'b1;
		exp_out_bits[0] = FIRST_OUT_RESET;
		exp_in_bits[0] = FIRST_IN_RESET;
		exp_out_bits[1] = SECOND_OUT_RESET;
		exp_in_bits[1] = SECOND_IN_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_ticks();
		test_zero_counts();
		test_short_access();
		test_random_accesses();
		drain_results();
		if (mismatches == 0)
			$display("serial_latch_expander_access verification clean");
		else
			$display("serial_latch_expander_access verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
design/slea_pkg.sv
design/slea_cfg.sv
design/slea_engine.sv
design/serial_latch_expander_access.sv
verif/serial_latch_expander_access_test.sv
